// File: rtl/stk_pkg.sv
// Shared types, codes and constants of the script tokenizer.
package stk_pkg;

  // Width of the byte offset, token start and token length counters
  localparam int POS_BITS = 16;

  // Result queue geometry
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  // Token kinds
  localparam logic [4:0] K_END   = 5'd0;
  localparam logic [4:0] K_NL    = 5'd1;
  localparam logic [4:0] K_NUM   = 5'd2;
  localparam logic [4:0] K_ID    = 5'd3;
  localparam logic [4:0] K_VAR   = 5'd4;
  localparam logic [4:0] K_IF    = 5'd5;
  localparam logic [4:0] K_ELSE  = 5'd6;
  localparam logic [4:0] K_FOR   = 5'd7;
  localparam logic [4:0] K_WHILE = 5'd8;
  localparam logic [4:0] K_STR   = 5'd9;
  localparam logic [4:0] K_PLUS  = 5'd10;
  localparam logic [4:0] K_MINUS = 5'd11;
  localparam logic [4:0] K_STAR  = 5'd12;
  localparam logic [4:0] K_SLASH = 5'd13;
  localparam logic [4:0] K_PCT   = 5'd14;
  localparam logic [4:0] K_LPAR  = 5'd15;
  localparam logic [4:0] K_RPAR  = 5'd16;
  localparam logic [4:0] K_LBRC  = 5'd17;
  localparam logic [4:0] K_RBRC  = 5'd18;
  localparam logic [4:0] K_COMMA = 5'd19;
  localparam logic [4:0] K_SEMI  = 5'd20;
  localparam logic [4:0] K_EQEQ  = 5'd21;
  localparam logic [4:0] K_EQ    = 5'd22;
  localparam logic [4:0] K_NE    = 5'd23;
  localparam logic [4:0] K_LE    = 5'd24;
  localparam logic [4:0] K_LT    = 5'd25;
  localparam logic [4:0] K_GE    = 5'd26;
  localparam logic [4:0] K_GT    = 5'd27;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // Keywords packed as the first identifier bytes, first byte highest
  localparam logic [39:0] WORD_VAR   = 40'h0000766172;
  localparam logic [39:0] WORD_IF    = 40'h0000006966;
  localparam logic [39:0] WORD_ELSE  = 40'h00656C7365;
  localparam logic [39:0] WORD_FOR   = 40'h0000666F72;
  localparam logic [39:0] WORD_WHILE = 40'h7768696C65;

  // Scanner modes
  typedef enum logic [3:0] {
    M_IDLE,
    M_IDENT,
    M_NUMBER,
    M_STRING,
    M_COMMENT,
    M_DOT,
    M_EQ,
    M_BANG,
    M_LT,
    M_GT,
    M_HALT
  } mode_t;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] line_number;
    logic [15:0] start_offset;
    logic [15:0] text_length;
    logic        bad_char;
    logic        last;
  } out_item_t;

  // Up to two results from one input item; b is only valid with a
  typedef struct packed {
    logic      valid_a;
    logic      valid_b;
    out_item_t a;
    out_item_t b;
  } res_pair_t;

endpackage

// File: rtl/stk_scanner.sv
// Tokenizer state and the per-item scan logic producing up to two results.
module stk_scanner (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  stk_pkg::in_item_t  item,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  output stk_pkg::res_pair_t res
);

  typedef struct packed {
    stk_pkg::mode_t mode;
    stk_pkg::pos_t  tstart;
    stk_pkg::pos_t  tlen;
    logic           kp_load;
    logic           put;
    logic [4:0]     kind;
    logic           bad;
    logic           len_one;
    logic           line_inc;
  } fresh_t;

  localparam stk_pkg::pos_t POS_MAX = '1;

  stk_pkg::mode_t mode, mode_next;
  logic [15:0]    first_line, first_line_next;
  logic [15:0]    line_count, line_count_next;
  stk_pkg::pos_t  byte_offset, byte_offset_next;
  stk_pkg::pos_t  token_start, token_start_next;
  stk_pkg::pos_t  token_length, token_length_next;
  logic [39:0]    keyword_prefix, keyword_prefix_next;

  function automatic stk_pkg::pos_t pos_inc(input stk_pkg::pos_t v);
    return (v != POS_MAX) ? v + stk_pkg::pos_t'(1) : v;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  // Identifier or one of the keywords
  function automatic logic [4:0] ident_kind(input stk_pkg::pos_t len, input logic [39:0] kp);
    logic [4:0] k;
    k = stk_pkg::K_ID;
    if (len == stk_pkg::pos_t'(3) && kp == stk_pkg::WORD_VAR)   k = stk_pkg::K_VAR;
    if (len == stk_pkg::pos_t'(2) && kp == stk_pkg::WORD_IF)    k = stk_pkg::K_IF;
    if (len == stk_pkg::pos_t'(4) && kp == stk_pkg::WORD_ELSE)  k = stk_pkg::K_ELSE;
    if (len == stk_pkg::pos_t'(3) && kp == stk_pkg::WORD_FOR)   k = stk_pkg::K_FOR;
    if (len == stk_pkg::pos_t'(5) && kp == stk_pkg::WORD_WHILE) k = stk_pkg::K_WHILE;
    return k;
  endfunction

  // Start scanning a byte with no token open
  function automatic fresh_t fresh(input logic [7:0] c, input stk_pkg::pos_t p);
    fresh_t f;
    f.mode     = stk_pkg::M_IDLE;
    f.tstart   = p;
    f.tlen     = stk_pkg::pos_t'(1);
    f.kp_load  = 1'b0;
    f.put      = 1'b0;
    f.kind     = stk_pkg::K_END;
    f.bad      = 1'b0;
    f.len_one  = 1'b1;
    f.line_inc = 1'b0;
    case (c)
      " ", "\t": ;
      "#":  f.mode = stk_pkg::M_COMMENT;
      "\n": begin
        f.put      = 1'b1;
        f.kind     = stk_pkg::K_NL;
        f.line_inc = 1'b1;
      end
      ".":  f.mode = stk_pkg::M_DOT;
      "\"": begin
        f.mode   = stk_pkg::M_STRING;
        f.tstart = pos_inc(p);
        f.tlen   = '0;
      end
      "=":  f.mode = stk_pkg::M_EQ;
      "!":  f.mode = stk_pkg::M_BANG;
      "<":  f.mode = stk_pkg::M_LT;
      ">":  f.mode = stk_pkg::M_GT;
      "+":  begin f.put = 1'b1; f.kind = stk_pkg::K_PLUS;  end
      "-":  begin f.put = 1'b1; f.kind = stk_pkg::K_MINUS; end
      "*":  begin f.put = 1'b1; f.kind = stk_pkg::K_STAR;  end
      "/":  begin f.put = 1'b1; f.kind = stk_pkg::K_SLASH; end
      "%":  begin f.put = 1'b1; f.kind = stk_pkg::K_PCT;   end
      "(":  begin f.put = 1'b1; f.kind = stk_pkg::K_LPAR;  end
      ")":  begin f.put = 1'b1; f.kind = stk_pkg::K_RPAR;  end
      "{":  begin f.put = 1'b1; f.kind = stk_pkg::K_LBRC;  end
      "}":  begin f.put = 1'b1; f.kind = stk_pkg::K_RBRC;  end
      ",":  begin f.put = 1'b1; f.kind = stk_pkg::K_COMMA; end
      ";":  begin f.put = 1'b1; f.kind = stk_pkg::K_SEMI;  end
      default: begin
        if (is_digit(c)) begin
          f.mode = stk_pkg::M_NUMBER;
        end else if (is_alpha(c) || c == "_") begin
          f.mode    = stk_pkg::M_IDENT;
          f.kp_load = 1'b1;
        end else begin
          // bad byte: end token, then halt
          f.put     = 1'b1;
          f.kind    = stk_pkg::K_END;
          f.bad     = 1'b1;
          f.len_one = 1'b0;
          f.mode    = stk_pkg::M_HALT;
        end
      end
    endcase
    return f;
  endfunction

  function automatic stk_pkg::out_item_t mk(input logic [4:0] kind, input stk_pkg::pos_t start,
                                            input stk_pkg::pos_t len, input logic bad,
                                            input logic [15:0] line);
    stk_pkg::out_item_t o;
    o.token_kind   = kind;
    o.line_number  = line;
    o.start_offset = 16'(start);
    o.text_length  = 16'(len);
    o.bad_char     = bad;
    o.last         = 1'b0;
    return o;
  endfunction

  // Per-item scan
  always_comb begin
    logic [7:0]         c;
    stk_pkg::pos_t      p;
    fresh_t             f;
    logic               do_fresh;
    logic               put_a;
    logic               put_b;
    stk_pkg::out_item_t ra;
    stk_pkg::out_item_t rb;

    c        = item.char_code;
    p        = byte_offset;
    f        = fresh(c, p);
    do_fresh = 1'b0;
    put_a    = 1'b0;
    put_b    = 1'b0;
    ra       = mk(stk_pkg::K_END, token_start, '0, 1'b0, line_count);
    rb       = mk(stk_pkg::K_END, byte_offset, '0, 1'b0, line_count);

    mode_next           = mode;
    first_line_next     = first_line;
    line_count_next     = line_count;
    byte_offset_next    = byte_offset;
    token_start_next    = token_start;
    token_length_next   = token_length;
    keyword_prefix_next = keyword_prefix;

    if (cfg_write) begin
      first_line_next = cfg_data;
      if (byte_offset == '0 && mode == stk_pkg::M_IDLE) line_count_next = cfg_data;
    end

    if (take && item.opcode == stk_pkg::OP_BYTE && mode != stk_pkg::M_HALT) begin
      byte_offset_next = pos_inc(byte_offset);
      case (mode)
        stk_pkg::M_IDENT: begin
          if (is_word(c)) begin
            if (token_length < stk_pkg::pos_t'(5)) keyword_prefix_next = {keyword_prefix[31:0], c};
            token_length_next = pos_inc(token_length);
          end else begin
            put_a    = 1'b1;
            ra       = mk(ident_kind(token_length, keyword_prefix), token_start, token_length,
                          1'b0, line_count);
            do_fresh = 1'b1;
          end
        end
        stk_pkg::M_NUMBER: begin
          if (is_digit(c) || c == "." || c == "-") begin
            token_length_next = pos_inc(token_length);
          end else begin
            put_a    = 1'b1;
            ra       = mk(stk_pkg::K_NUM, token_start, token_length, 1'b0, line_count);
            do_fresh = 1'b1;
          end
        end
        stk_pkg::M_STRING: begin
          if (c == "\"") begin
            put_a     = 1'b1;
            ra        = mk(stk_pkg::K_STR, token_start, token_length, 1'b0, line_count);
            mode_next = stk_pkg::M_IDLE;
          end else begin
            token_length_next = pos_inc(token_length);
          end
        end
        stk_pkg::M_COMMENT: begin
          if (c == "\n") do_fresh = 1'b1;
        end
        stk_pkg::M_DOT: begin
          if (is_digit(c)) begin
            mode_next         = stk_pkg::M_NUMBER;
            token_length_next = stk_pkg::pos_t'(2);
          end else begin
            put_a     = 1'b1;
            ra        = mk(stk_pkg::K_END, token_start, '0, 1'b1, line_count);
            mode_next = stk_pkg::M_HALT;
          end
        end
        stk_pkg::M_BANG: begin
          put_a = 1'b1;
          if (c == "=") begin
            ra        = mk(stk_pkg::K_NE, token_start, stk_pkg::pos_t'(2), 1'b0, line_count);
            mode_next = stk_pkg::M_IDLE;
          end else begin
            ra        = mk(stk_pkg::K_END, token_start, '0, 1'b1, line_count);
            mode_next = stk_pkg::M_HALT;
          end
        end
        stk_pkg::M_EQ, stk_pkg::M_LT, stk_pkg::M_GT: begin
          put_a = 1'b1;
          if (c == "=") begin
            ra = mk((mode == stk_pkg::M_EQ) ? stk_pkg::K_EQEQ :
                    (mode == stk_pkg::M_LT) ? stk_pkg::K_LE : stk_pkg::K_GE,
                    token_start, stk_pkg::pos_t'(2), 1'b0, line_count);
            mode_next = stk_pkg::M_IDLE;
          end else begin
            ra = mk((mode == stk_pkg::M_EQ) ? stk_pkg::K_EQ :
                    (mode == stk_pkg::M_LT) ? stk_pkg::K_LT : stk_pkg::K_GT,
                    token_start, stk_pkg::pos_t'(1), 1'b0, line_count);
            do_fresh = 1'b1;
          end
        end
        default: do_fresh = 1'b1;
      endcase

      // Byte scanned afresh, possibly after a closed token
      if (do_fresh) begin
        mode_next         = f.mode;
        token_start_next  = f.tstart;
        token_length_next = f.tlen;
        if (f.kp_load) keyword_prefix_next = {32'd0, c};
        if (f.line_inc && line_count != 16'hFFFF) line_count_next = line_count + 16'd1;
        put_b = f.put;
        rb    = mk(f.kind, p, f.len_one ? stk_pkg::pos_t'(1) : '0, f.bad, line_count);
      end
    end else if (take && item.opcode == stk_pkg::OP_EOS) begin
      // Flush the open token, then the end token unless the source halted
      put_b = (mode != stk_pkg::M_HALT);
      rb    = mk(stk_pkg::K_END, byte_offset, '0, 1'b0, line_count);
      case (mode)
        stk_pkg::M_IDENT: begin
          put_a = 1'b1;
          ra    = mk(ident_kind(token_length, keyword_prefix), token_start, token_length,
                     1'b0, line_count);
        end
        stk_pkg::M_NUMBER: begin
          put_a = 1'b1;
          ra    = mk(stk_pkg::K_NUM, token_start, token_length, 1'b0, line_count);
        end
        stk_pkg::M_STRING: begin
          put_a = 1'b1;
          ra    = mk(stk_pkg::K_STR, token_start, token_length, 1'b0, line_count);
        end
        stk_pkg::M_DOT, stk_pkg::M_BANG: begin
          put_a = 1'b1;
          put_b = 1'b0;
          ra    = mk(stk_pkg::K_END, token_start, '0, 1'b1, line_count);
        end
        stk_pkg::M_EQ: begin
          put_a = 1'b1;
          ra    = mk(stk_pkg::K_EQ, token_start, stk_pkg::pos_t'(1), 1'b0, line_count);
        end
        stk_pkg::M_LT: begin
          put_a = 1'b1;
          ra    = mk(stk_pkg::K_LT, token_start, stk_pkg::pos_t'(1), 1'b0, line_count);
        end
        stk_pkg::M_GT: begin
          put_a = 1'b1;
          ra    = mk(stk_pkg::K_GT, token_start, stk_pkg::pos_t'(1), 1'b0, line_count);
        end
        default: ;
      endcase
      // Restart for a new source
      mode_next           = stk_pkg::M_IDLE;
      line_count_next     = first_line;
      byte_offset_next    = '0;
      token_start_next    = '0;
      token_length_next   = '0;
      keyword_prefix_next = '0;
    end

    // Pack results so the first one always sits in slot a
    if (put_a) begin
      res.valid_a = 1'b1;
      res.valid_b = put_b;
      res.a       = ra;
      res.b       = rb;
    end else begin
      res.valid_a = put_b;
      res.valid_b = 1'b0;
      res.a       = rb;
      res.b       = rb;
    end
    res.a.last = !res.valid_b;
    res.b.last = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= stk_pkg::M_IDLE;
      first_line     <= 16'd1;
      line_count     <= 16'd1;
      byte_offset    <= '0;
      token_start    <= '0;
      token_length   <= '0;
      keyword_prefix <= '0;
    end else begin
      mode           <= mode_next;
      first_line     <= first_line_next;
      line_count     <= line_count_next;
      byte_offset    <= byte_offset_next;
      token_start    <= token_start_next;
      token_length   <= token_length_next;
      keyword_prefix <= keyword_prefix_next;
    end
  end

endmodule

// File: rtl/stk_result_queue.sv
// Small result queue taking up to two results per cycle and giving one per cycle while out_stall is low.
module stk_result_queue (
  input  logic               clk,
  input  logic               rst,
  input  stk_pkg::res_pair_t res,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output stk_pkg::out_item_t out_item
);

  stk_pkg::out_item_t                mem [stk_pkg::Q_DEPTH];
  logic [stk_pkg::Q_PTR_BITS-1:0]    wr_ptr, rd_ptr;
  logic [stk_pkg::Q_CNT_BITS-1:0]    count;
  logic                              pop;
  logic [stk_pkg::Q_CNT_BITS-1:0]    push_n;

  assign pop       = out_valid && !out_stall;
  assign push_n    = stk_pkg::Q_CNT_BITS'(res.valid_a) + stk_pkg::Q_CNT_BITS'(res.valid_b);
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  // Room for two results must stand free before an item is taken
  assign full      = (count > stk_pkg::Q_CNT_BITS'(stk_pkg::Q_DEPTH - 2));

  // Entry storage
  always_ff @(posedge clk) begin
    if (res.valid_a) mem[wr_ptr] <= res.a;
    if (res.valid_b) mem[wr_ptr + stk_pkg::Q_PTR_BITS'(1)] <= res.b;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + stk_pkg::Q_PTR_BITS'(push_n);
      if (pop) rd_ptr <= rd_ptr + stk_pkg::Q_PTR_BITS'(1);
      count  <= count + push_n - stk_pkg::Q_CNT_BITS'(pop);
    end
  end

endmodule

// File: rtl/script_tokenizer_top.sv
// Top level of the script tokenizer: scanner feeding the result queue.
//
// The tokenizer takes one item per cycle while in_stall is low, a source byte
// or an end of source, and scans it in the cycle it is accepted: the scanner
// state registers hold the open token and the positions, and its results go
// straight into a four-entry result queue from which one token leaves per
// cycle while out_stall is low. An item closes at most two tokens; in_stall
// rises while fewer than two queue entries are free, so a run of items that
// each give two tokens is held back by the single output beat per cycle. A
// new source restarts at offset zero and at the first_line register value;
// no clearing pass is needed after reset.
module script_tokenizer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  stk_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output stk_pkg::out_item_t out_item,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data
);

  stk_pkg::res_pair_t res;
  logic               take;

  assign take = in_valid && !in_stall;

  stk_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (in_item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  stk_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: rtl/stk_checker.sv
// Port-level checks of the script tokenizer and their bind to the top level.
module stk_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input stk_pkg::out_item_t out_item
);

  // A stalled result stays offered and unchanged
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // The end token closes the results of its item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.token_kind == stk_pkg::K_END |-> out_item.last)
    else $error("end token not marked last");

  // A bad-byte flag only rides on an empty end token
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.bad_char |->
      out_item.token_kind == stk_pkg::K_END && out_item.text_length == 16'd0)
    else $error("bad_char on a non-end token");

  // Newline tokens are one byte long
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.token_kind == stk_pkg::K_NL |-> out_item.text_length == 16'd1)
    else $error("newline token length is not one");

  // An empty result queue never holds off the input
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result waiting");

endmodule

bind script_tokenizer_top stk_checker u_stk_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// File: bench/tok_checker.sv
// Token stream checker: predicts every token of the tokenizer and compares it on the output.
module tok_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  stk_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  stk_pkg::out_item_t out_item,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  output int                 err_count,
  output int                 tokens_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import stk_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [15:0] POS_TOP = 16'hFFFF;
  localparam int MAX_REPORTS = 60;

  // Scanner copy
  logic [15:0] first_line_q;
  mode_t       mode_q;
  logic [15:0] line_q;
  logic [15:0] offs_q;
  logic [15:0] tstart_q;
  logic [15:0] tlen_q;
  logic [39:0] prefix_q;

  out_item_t   item_toks[$];   // tokens caused by the item being scanned
  out_item_t   due_toks[$];    // tokens predicted and not yet seen
  int          errors = 0;
  int          due_count = 0;

  assign err_count  = errors;
  assign tokens_due = due_count;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == POS_TOP) ? v : v + 16'd1;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  task automatic add_tok(logic [4:0] kind, logic [15:0] start, logic [15:0] len, logic bad);
    out_item_t t;
    t.token_kind   = kind;
    t.line_number  = line_q;
    t.start_offset = start;
    t.text_length  = len;
    t.bad_char     = bad;
    t.last         = 1'b0;
    item_toks.insert(item_toks.size(), t);
  endtask

  // Identifier or keyword; the prefix holds the exact text up to five bytes
  task automatic close_word();
    logic [4:0] kind;
    kind = K_ID;
    if (tlen_q == 16'd3 && prefix_q == WORD_VAR) kind = K_VAR;
    else if (tlen_q == 16'd2 && prefix_q == WORD_IF) kind = K_IF;
    else if (tlen_q == 16'd4 && prefix_q == WORD_ELSE) kind = K_ELSE;
    else if (tlen_q == 16'd3 && prefix_q == WORD_FOR) kind = K_FOR;
    else if (tlen_q == 16'd5 && prefix_q == WORD_WHILE) kind = K_WHILE;
    add_tok(kind, tstart_q, tlen_q, 1'b0);
  endtask

  task automatic halt_at(logic [15:0] at);
    add_tok(K_END, at, 16'd0, 1'b1);
    mode_q = M_HALT;
  endtask

  // Byte seen between tokens
  task automatic start_token(logic [7:0] c, logic [15:0] p);
    mode_q   = M_IDLE;
    tstart_q = p;
    tlen_q   = 16'd1;
    case (c)
      CH_SPACE, CH_TAB: ;
      CH_HASH:  mode_q = M_COMMENT;
      CH_NL: begin
        add_tok(K_NL, p, 16'd1, 1'b0);
        if (line_q != 16'hFFFF) line_q = line_q + 16'd1;
      end
      CH_DOT:   mode_q = M_DOT;
      CH_QUOTE: begin
        mode_q   = M_STRING;
        tstart_q = sat_inc(p);
        tlen_q   = 16'd0;
      end
      CH_EQ:    mode_q = M_EQ;
      CH_BANG:  mode_q = M_BANG;
      CH_LT:    mode_q = M_LT;
      CH_GT:    mode_q = M_GT;
      CH_PLUS:  add_tok(K_PLUS, p, 16'd1, 1'b0);
      CH_MINUS: add_tok(K_MINUS, p, 16'd1, 1'b0);
      CH_STAR:  add_tok(K_STAR, p, 16'd1, 1'b0);
      CH_SLASH: add_tok(K_SLASH, p, 16'd1, 1'b0);
      CH_PCT:   add_tok(K_PCT, p, 16'd1, 1'b0);
      CH_LPAR:  add_tok(K_LPAR, p, 16'd1, 1'b0);
      CH_RPAR:  add_tok(K_RPAR, p, 16'd1, 1'b0);
      CH_LBRC:  add_tok(K_LBRC, p, 16'd1, 1'b0);
      CH_RBRC:  add_tok(K_RBRC, p, 16'd1, 1'b0);
      CH_COMMA: add_tok(K_COMMA, p, 16'd1, 1'b0);
      CH_SEMI:  add_tok(K_SEMI, p, 16'd1, 1'b0);
      default: begin
        if (is_digit(c)) begin
          mode_q = M_NUMBER;
        end else if (is_alpha(c) || c == CH_UNDER) begin
          mode_q   = M_IDENT;
          prefix_q = {32'd0, c};
        end else begin
          halt_at(p);
        end
      end
    endcase
  endtask

  // Pending '=', '<', '>' resolved by the next byte
  task automatic pair_or_single(logic [7:0] c, logic [15:0] p, logic [4:0] pair_kind,
                                logic [4:0] single_kind);
    if (c == CH_EQ) begin
      add_tok(pair_kind, tstart_q, 16'd2, 1'b0);
      mode_q = M_IDLE;
    end else begin
      add_tok(single_kind, tstart_q, 16'd1, 1'b0);
      start_token(c, p);
    end
  endtask

  task automatic scan_char(logic [7:0] c, logic [15:0] p);
    case (mode_q)
      M_IDENT: begin
        if (is_word(c)) begin
          if (tlen_q < 16'd5) prefix_q = {prefix_q[31:0], c};
          tlen_q = sat_inc(tlen_q);
        end else begin
          close_word();
          start_token(c, p);
        end
      end
      M_NUMBER: begin
        if (is_digit(c) || c == CH_DOT || c == CH_MINUS) begin
          tlen_q = sat_inc(tlen_q);
        end else begin
          add_tok(K_NUM, tstart_q, tlen_q, 1'b0);
          start_token(c, p);
        end
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          add_tok(K_STR, tstart_q, tlen_q, 1'b0);
          mode_q = M_IDLE;
        end else begin
          tlen_q = sat_inc(tlen_q);
        end
      end
      M_COMMENT: if (c == CH_NL) start_token(c, p);
      M_DOT: begin
        if (is_digit(c)) begin
          mode_q = M_NUMBER;
          tlen_q = 16'd2;
        end else begin
          halt_at(tstart_q);
        end
      end
      M_BANG: begin
        if (c == CH_EQ) begin
          add_tok(K_NE, tstart_q, 16'd2, 1'b0);
          mode_q = M_IDLE;
        end else begin
          halt_at(tstart_q);
        end
      end
      M_EQ: pair_or_single(c, p, K_EQEQ, K_EQ);
      M_LT: pair_or_single(c, p, K_LE, K_LT);
      M_GT: pair_or_single(c, p, K_GE, K_GT);
      M_HALT: ;
      default: start_token(c, p);
    endcase
  endtask

  task automatic restart_source();
    mode_q   = M_IDLE;
    line_q   = first_line_q;
    offs_q   = 16'd0;
    tstart_q = 16'd0;
    tlen_q   = 16'd0;
    prefix_q = 40'd0;
  endtask

  // Tokens caused by one accepted item, queued in order with last on the final one
  task automatic predict_item(in_item_t it);
    logic [15:0] p;
    bit          halted;
    out_item_t   t;
    item_toks.delete();
    if (it.opcode == OP_BYTE) begin
      if (mode_q != M_HALT) begin
        p      = offs_q;
        offs_q = sat_inc(offs_q);
        scan_char(it.char_code, p);
      end
    end else begin
      halted = 1'b0;
      case (mode_q)
        M_HALT:   halted = 1'b1;
        M_IDENT:  close_word();
        M_NUMBER: add_tok(K_NUM, tstart_q, tlen_q, 1'b0);
        M_STRING: add_tok(K_STR, tstart_q, tlen_q, 1'b0);
        M_DOT, M_BANG: begin
          add_tok(K_END, tstart_q, 16'd0, 1'b1);
          halted = 1'b1;
        end
        M_EQ:     add_tok(K_EQ, tstart_q, 16'd1, 1'b0);
        M_LT:     add_tok(K_LT, tstart_q, 16'd1, 1'b0);
        M_GT:     add_tok(K_GT, tstart_q, 16'd1, 1'b0);
        default: ;
      endcase
      if (!halted) add_tok(K_END, offs_q, 16'd0, 1'b0);
      restart_source();
    end
    if (item_toks.size() > 0) begin
      t = item_toks[item_toks.size() - 1];
      t.last = 1'b1;
      item_toks[item_toks.size() - 1] = t;
    end
    foreach (item_toks[i]) due_toks.insert(due_toks.size(), item_toks[i]);
  endtask

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // Watch both channels and the register port
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      first_line_q = 16'd1;
      restart_source();
      due_toks.delete();
    end else begin
      if (cfg_write) begin
        first_line_q = cfg_data;
        if (offs_q == 16'd0 && mode_q == M_IDLE) line_q = first_line_q;
      end
      if (in_valid && !in_stall) predict_item(in_item);
      if (out_valid && !out_stall) begin
        if (due_toks.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: token with nothing due, expected none actual kind %0d start %0h",
                     $time, out_item.token_kind, out_item.start_offset);
          errors++;
        end else begin
          want = due_toks.pop_front();
          check_field("token_kind", 16'(want.token_kind), 16'(out_item.token_kind));
          check_field("line_number", want.line_number, out_item.line_number);
          check_field("start_offset", want.start_offset, out_item.start_offset);
          check_field("text_length", want.text_length, out_item.text_length);
          check_field("bad_char", 16'(want.bad_char), 16'(out_item.bad_char));
          check_field("last", 16'(want.last), 16'(out_item.last));
        end
      end
    end
    due_count <= due_toks.size();
  end

endmodule

// File: bench/tb_top.sv
// Testbench top of the script tokenizer: clock, reset, source stimulus, receiver stalls, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stk_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_Q     = 8'h71;

  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PHASE_ITEMS   = 300;
  localparam int NUM_PHASES    = 6;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  in_item_t           in_item = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b1;
  out_item_t          out_item;
  logic               cfg_write = 1'b0;
  logic [15:0]        cfg_data = 16'd0;
  int                 err_count;
  int                 tokens_due;

  bit                 hold_req = 1'b0;
  bit                 dense = 1'b0;
  int                 items_sent = 0;
  int                 quiet_cycles = 0;

  // letters first, then underscore, then digits
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string num_chars  = "0123456789.-";
  string op_chars   = "+-*/%(){},;";

  always #5 clk = ~clk;

  script_tokenizer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  tok_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .err_count  (err_count),
    .tokens_due (tokens_due)
  );

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stall runs, and once a long hold-off while the sender keeps offering
  initial begin
    int run;
    int r;
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_stall <= 1'b0;
          run = $urandom_range(1, 24);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(8, 50);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (dense) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item from a rising edge, return at the edge that takes it (plus any gap)
  task automatic send_item(logic op, logic [7:0] c);
    bit stalled;
    int gap;
    in_valid <= 1'b1;
    in_item  <= {op, c};
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_byte(logic [7:0] c);
    send_item(OP_BYTE, c);
  endtask

  // end of source carries a random, ignored byte
  task automatic send_end();
    send_item(OP_EOS, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  function automatic string keyword_text(int i);
    case (i)
      0: return "var";
      1: return "if";
      2: return "else";
      3: return "for";
      default: return "while";
    endcase
  endfunction

  function automatic string pending_op_text(int i);
    case (i)
      0: return "==";
      1: return "!=";
      2: return "<=";
      3: return ">=";
      4: return "=";
      5: return "<";
      default: return ">";
    endcase
  endfunction

  // One token with random content, sometimes malformed, or now and then a noise byte
  task automatic send_token();
    int         r;
    int         n;
    string      kw;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      send_text(keyword_text($urandom_range(0, 4)));
      send_byte(CH_SPACE);
    end else if (r < 24) begin
      // identifiers, many of them close to a keyword
      kw = keyword_text($urandom_range(0, 4));
      case ($urandom_range(0, 2))
        0: send_text(kw);
        1: send_text(kw.substr(0, kw.len() - 2));
        default: send_byte(word_chars[$urandom_range(0, 52)]);
      endcase
      n = $urandom_range(0, 6);
      repeat (n) send_byte(word_chars[$urandom_range(0, 62)]);
    end else if (r < 36) begin
      if ($urandom_range(0, 3) == 0) send_byte(CH_DOT);
      send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      n = $urandom_range(0, 6);
      repeat (n) send_byte(num_chars[$urandom_range(0, 11)]);
    end else if (r < 44) begin
      send_byte(CH_QUOTE);
      n = $urandom_range(0, 8);
      repeat (n) begin
        c = ($urandom_range(0, 6) == 0) ? CH_NL : 8'($urandom_range(0, 255));
        if (c == CH_QUOTE) c = CH_Q;
        send_byte(c);
      end
      if ($urandom_range(0, 9) != 0) send_byte(CH_QUOTE);
    end else if (r < 49) begin
      send_byte(CH_HASH);
      n = $urandom_range(0, 8);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_NL) c = CH_Q;
        send_byte(c);
      end
      send_byte(CH_NL);
    end else if (r < 57) begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end else if (r < 63) begin
      send_byte(CH_NL);
    end else if (r < 77) begin
      send_byte(op_chars[$urandom_range(0, 10)]);
    end else if (r < 90) begin
      send_text(pending_op_text($urandom_range(0, 6)));
    end else if (r < 98) begin
      send_byte(CH_SPACE);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_source();
    int ntok;
    dense = ($urandom_range(0, 4) == 0);
    ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    repeat (ntok) send_token();
    if ($urandom_range(0, 9) != 0) send_end();
  endtask

  // Stop offering and wait until every due token has come and the scanner has settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (tokens_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_first_line(logic [15:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    logic [15:0] line_setting;
    int          target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: keyword, pair and single operators, dot number, comment,
    // string over a newline left open at end of source
    send_text("while x1>=.5-2<y #z\n\"a\nb");
    send_end();
    // lone bang, then end of a halted source
    send_text("!x");
    send_end();
    // lone dot at end of source
    send_byte(CH_DOT);
    send_end();
    // byte above 127
    send_byte(8'hFF);
    send_end();
    // pending '<' flushed by end of source
    send_byte(8'h3C);
    send_end();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: line_setting = 16'd0;
        1: line_setting = 16'hFFFF;
        2: line_setting = 16'hFFFE;
        3: line_setting = 16'($urandom_range(0, 65535));
        4: line_setting = 16'd1;
        default: line_setting = 16'($urandom_range(2, 300));
      endcase
      write_first_line(line_setting);
      if (ph == 1) begin
        // long receiver hold-off with the sender offering back to back
        hold_req = 1'b1;
        dense = 1'b1;
        repeat (40) send_token();
        send_end();
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_source();
      // leave a source open so the next write does not reload the line count
      if (ph == 3) send_text("ab");
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (err_count == 0 && tokens_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/stk_pkg.sv
rtl/stk_scanner.sv
rtl/stk_result_queue.sv
rtl/script_tokenizer_top.sv
rtl/stk_checker.sv
bench/tok_checker.sv
bench/tb_top.sv
